[rtl/core/cdda_pkg.sv]
// ----------------------------------------------------------------------------
// cdda_pkg
// Shared types, codes and small constant tables of the date arithmetic core.
// ----------------------------------------------------------------------------
package cdda_pkg;

    // operation codes
    localparam logic KIND_SHIFT = 1'b0;
    localparam logic KIND_DIFF  = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEFAULT_MONTH = 2'd0;
    localparam logic [1:0] REG_DEFAULT_DAY   = 2'd1;
    localparam logic [1:0] REG_DEFAULT_YEAR  = 2'd2;

    // depth of the Julian day to calendar date pipeline
    localparam int FJ_LAT = 9;

    // request fields carried alongside the front half of the pipe
    typedef struct packed {
        logic               kind;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [13:0]        year;
        logic signed [22:0] offset;
        logic [3:0]         other_month;
        logic [4:0]         other_day;
        logic [13:0]        other_year;
    } side_t;

    // Julian day numbers of the two input dates
    typedef struct packed {
        logic [23:0] jd_main;
        logic [23:0] jd_other;
    } jpair_t;

    // state carried alongside the back half of the pipe
    typedef struct packed {
        logic               kind;
        logic               main_ok;
        logic               other_ok;
        logic [3:0]         base_month;
        logic [4:0]         base_day;
        logic [13:0]        base_year;
        logic [23:0]        base_jd;
        logic [22:0]        diff;
        logic signed [24:0] jd_shift;
        logic               neg;
    } mid_t;

    // floor(367 * (m - 2 - 12a) / 12), a = -1 for months 0..2
    function automatic logic [8:0] month_term(input logic [3:0] m);
        logic [8:0] t;
        case (m)
            4'd0:    t = 9'd305;
            4'd1:    t = 9'd336;
            4'd2:    t = 9'd367;
            4'd3:    t = 9'd30;
            4'd4:    t = 9'd61;
            4'd5:    t = 9'd91;
            4'd6:    t = 9'd122;
            4'd7:    t = 9'd152;
            4'd8:    t = 9'd183;
            4'd9:    t = 9'd214;
            4'd10:   t = 9'd244;
            4'd11:   t = 9'd275;
            4'd12:   t = 9'd305;
            4'd13:   t = 9'd336;
            4'd14:   t = 9'd367;
            default: t = 9'd397;
        endcase
        return t;
    endfunction

    // floor(2447 * j / 80)
    function automatic logic [8:0] k_term(input logic [3:0] j);
        logic [8:0] t;
        case (j)
            4'd0:    t = 9'd0;
            4'd1:    t = 9'd30;
            4'd2:    t = 9'd61;
            4'd3:    t = 9'd91;
            4'd4:    t = 9'd122;
            4'd5:    t = 9'd152;
            4'd6:    t = 9'd183;
            4'd7:    t = 9'd214;
            4'd8:    t = 9'd244;
            4'd9:    t = 9'd275;
            4'd10:   t = 9'd305;
            4'd11:   t = 9'd336;
            4'd12:   t = 9'd367;
            4'd13:   t = 9'd397;
            4'd14:   t = 9'd428;
            default: t = 9'd458;
        endcase
        return t;
    endfunction

endpackage

[rtl/core/cdda_fj.sv]
// ----------------------------------------------------------------------------
// cdda_fj
// Julian day number to calendar date, nine register stages, one enable.
// ----------------------------------------------------------------------------
module cdda_fj (
    input  logic               aclk,
    input  logic               en,
    input  logic [23:0]        jd,
    output logic [3:0]         month,
    output logic [4:0]         day,
    output logic signed [15:0] year
);

    // reciprocals: q0 = (v * M) >> S is q or q - 1, fixed up one stage later
    localparam int S1 = 25;
    localparam int M1 = (4 * (2 ** S1)) / 146097;
    localparam int S2 = 16;
    localparam int M2 = (4000 * (2 ** S2)) / 1461001;
    localparam int S3 = 10;
    localparam int M3 = (80 * (2 ** S3)) / 2447;

    logic [24:0] l1_reg;
    logic [9:0]  q1_reg;
    logic [24:0] l2_reg;
    logic [9:0]  n2_reg;
    logic [15:0] ls3_reg;
    logic [9:0]  n3_reg;
    logic [15:0] ls4_reg;
    logic [6:0]  q4_reg;
    logic [9:0]  n4_reg;
    logic [15:0] ls5_reg;
    logic [6:0]  i5_reg;
    logic [9:0]  n5_reg;
    logic [9:0]  l6_reg;
    logic [6:0]  i6_reg;
    logic [9:0]  n6_reg;
    logic [9:0]  l7_reg;
    logic [5:0]  q7_reg;
    logic [6:0]  i7_reg;
    logic [9:0]  n7_reg;
    logic [9:0]  l8_reg;
    logic [3:0]  j8_reg;
    logic [6:0]  i8_reg;
    logic [9:0]  n8_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [15:0] year_reg;

    logic [24:0] l1_next;
    logic [34:0] prod1;
    logic [26:0] rem2;
    logic [26:0] sub3;
    logic [16:0] v4;
    logic [23:0] prod4;
    logic [16:0] v5;
    logic [27:0] rem5;
    logic [17:0] l6_next;
    logic [15:0] prod7;
    logic [16:0] rem8;
    logic        lf9;
    logic [17:0] year9;

    always_comb begin
        l1_next = 25'(jd) + 25'd68569;
        prod1   = 35'(l1_next) * 35'(M1);
        rem2    = {l1_reg, 2'b00} - 27'(q1_reg) * 27'd146097;
        sub3    = 27'(l2_reg) - ((27'(n2_reg) * 27'd146097 + 27'd3) >> 2);
        v4      = 17'(ls3_reg) + 17'd1;
        prod4   = 24'(v4) * 24'(M2);
        v5      = 17'(ls4_reg) + 17'd1;
        rem5    = 28'(v5) * 28'd4000 - 28'(q4_reg) * 28'd1461001;
        l6_next = 18'(ls5_reg) - ((18'(i5_reg) * 18'd1461) >> 2) + 18'd31;
        prod7   = 16'(l6_reg) * 16'(M3);
        rem8    = 17'(l7_reg) * 17'd80 - 17'(q7_reg) * 17'd2447;
        lf9     = (j8_reg >= 4'd11);
        year9   = 18'(n8_reg) * 18'd100 - 18'd4900 + 18'(i8_reg) + 18'(lf9);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_reg    <= l1_next;
            q1_reg    <= 10'(prod1 >> S1);
            l2_reg    <= l1_reg;
            n2_reg    <= q1_reg + 10'(rem2 >= 27'd146097);
            ls3_reg   <= sub3[15:0];
            n3_reg    <= n2_reg;
            ls4_reg   <= ls3_reg;
            q4_reg    <= 7'(prod4 >> S2);
            n4_reg    <= n3_reg;
            ls5_reg   <= ls4_reg;
            i5_reg    <= q4_reg + 7'(rem5 >= 28'd1461001);
            n5_reg    <= n4_reg;
            l6_reg    <= l6_next[9:0];
            i6_reg    <= i5_reg;
            n6_reg    <= n5_reg;
            l7_reg    <= l6_reg;
            q7_reg    <= 6'(prod7 >> S3);
            i7_reg    <= i6_reg;
            n7_reg    <= n6_reg;
            l8_reg    <= l7_reg;
            j8_reg    <= 4'(q7_reg + 6'(rem8 >= 17'd2447));
            i8_reg    <= i7_reg;
            n8_reg    <= n7_reg;
            day_reg   <= 5'(l8_reg - 10'(cdda_pkg::k_term(j8_reg)));
            month_reg <= lf9 ? 4'(j8_reg - 4'd10) : 4'(j8_reg + 4'd2);
            year_reg  <= year9[15:0];
        end
    end

    assign month = month_reg;
    assign day   = day_reg;
    assign year  = $signed(year_reg);

endmodule

[rtl/core/calendar_date_day_arithmetic.sv]
// ----------------------------------------------------------------------------
// calendar_date_day_arithmetic
// Gregorian date shift and date difference through Julian day numbers.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  s_       | s_valid / s_ready  | kind, date, offset, other date
//  m_       | m_valid / m_ready  | result date, julian day, difference, flags
//  apb      | psel/penable/pready| default month (0x0), day (0x4), year (0x8)
//
//  One request per cycle unless a stalled output holds the pipe.
//  The pipe is two passes through the nine-stage Julian-to-date pipe
//  plus three stages of date-to-Julian, one select and one output stage.
//  A stall freezes all but the default lane; s_ready is !m_valid || m_ready.
//  Reset clears the valid bits and loads the default date 1959-05-11.
// ----------------------------------------------------------------------------
module calendar_date_day_arithmetic (
    input  logic               aclk,
    input  logic               aresetn,
    // config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [3:0]         s_month,
    input  logic [4:0]         s_day,
    input  logic [13:0]        s_year,
    input  logic signed [22:0] s_offset,
    input  logic [3:0]         s_other_month,
    input  logic [4:0]         s_other_day,
    input  logic [13:0]        s_other_year,
    // result
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_result_month,
    output logic [4:0]         m_result_day,
    output logic [13:0]        m_result_year,
    output logic [22:0]        m_julian_day,
    output logic signed [22:0] m_day_difference,
    output logic               m_main_valid,
    output logic               m_other_valid,
    output logic               m_out_of_range
);

    localparam int NST = 23;

    // ---------------- configuration ----------------
    logic [3:0]  default_month_reg;
    logic [4:0]  default_day_reg;
    logic [13:0] default_year_reg;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_month_reg <= 4'd5;
            default_day_reg   <= 5'd11;
            default_year_reg  <= 14'd1959;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                cdda_pkg::REG_DEFAULT_MONTH: default_month_reg <= pwdata[3:0];
                cdda_pkg::REG_DEFAULT_DAY:   default_day_reg   <= pwdata[4:0];
                cdda_pkg::REG_DEFAULT_YEAR:  default_year_reg  <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            cdda_pkg::REG_DEFAULT_MONTH: prdata = 32'(default_month_reg);
            cdda_pkg::REG_DEFAULT_DAY:   prdata = 32'(default_day_reg);
            cdda_pkg::REG_DEFAULT_YEAR:  prdata = 32'(default_year_reg);
            default:                     prdata = 32'd0;
        endcase
    end

    // ---------------- pipe control ----------------
    // single enable: the pipe moves when the output slot is free or drained
    logic           en;
    logic [NST-1:0] vld_reg;

    assign en      = !vld_reg[NST-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // request fields ride along stages 1..12
    cdda_pkg::side_t side_next;
    cdda_pkg::side_t side_reg [12];

    assign side_next = '{kind: s_kind, month: s_month, day: s_day, year: s_year,
                         offset: s_offset, other_month: s_other_month,
                         other_day: s_other_day, other_year: s_other_year};

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < 12; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- date to Julian day, three lanes ----------------
    // lane 0 main date, lane 1 other date, lane 2 default date (free running)
    logic [2:0]  tj_en;
    logic [3:0]  tj_m [3];
    logic [4:0]  tj_d [3];
    logic [13:0] tj_y [3];
    logic [23:0] tj_jd_reg [3];

    assign tj_en   = {1'b1, en, en};
    assign tj_m[0] = s_month;
    assign tj_d[0] = s_day;
    assign tj_y[0] = s_year;
    assign tj_m[1] = s_other_month;
    assign tj_d[1] = s_other_day;
    assign tj_y[1] = s_other_year;
    assign tj_m[2] = default_month_reg;
    assign tj_d[2] = default_day_reg;
    assign tj_y[2] = default_year_reg;

    for (genvar k = 0; k < 3; k++) begin : g_tj
        logic        early;
        logic [14:0] ya;
        logic [14:0] u_next;
        logic [24:0] p1_reg;
        logic [14:0] u1_reg;
        logic [7:0]  q1_reg;
        logic [8:0]  t1_reg;
        logic [4:0]  d1_reg;
        logic [14:0] r2;
        logic [24:0] p2_reg;
        logic [7:0]  q2_reg;
        logic [8:0]  t2_reg;
        logic [4:0]  d2_reg;

        always_comb begin
            early  = (tj_m[k] <= 4'd2);
            ya     = 15'(tj_y[k]) + (early ? 15'd4799 : 15'd4800);
            u_next = 15'(tj_y[k]) + (early ? 15'd4899 : 15'd4900);
            r2     = u1_reg - 15'(15'(q1_reg) * 15'd100);
        end

        always_ff @(posedge aclk) begin
            if (tj_en[k]) begin
                p1_reg       <= 25'(ya) * 25'd1461;
                u1_reg       <= u_next;
                // /100 by reciprocal 655 / 2^16, corrected next stage
                q1_reg       <= 8'((24'(u_next) * 24'd655) >> 16);
                t1_reg       <= cdda_pkg::month_term(tj_m[k]);
                d1_reg       <= tj_d[k];
                p2_reg       <= p1_reg;
                q2_reg       <= q1_reg + 8'(r2 >= 15'd100);
                t2_reg       <= t1_reg;
                d2_reg       <= d1_reg;
                tj_jd_reg[k] <= 24'(p2_reg >> 2) + 24'(d2_reg) + 24'(t2_reg)
                                - 24'((10'(q2_reg) * 10'd3) >> 2) - 24'd32075;
            end
        end
    end

    logic [23:0] default_jd;
    assign default_jd = tj_jd_reg[2];

    // jd pair rides along stages 4..12
    cdda_pkg::jpair_t jd_pipe [cdda_pkg::FJ_LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            jd_pipe[0] <= '{jd_main: tj_jd_reg[0], jd_other: tj_jd_reg[1]};
            for (int i = 1; i < cdda_pkg::FJ_LAT; i++) begin
                jd_pipe[i] <= jd_pipe[i-1];
            end
        end
    end

    // ---------------- round trip checks ----------------
    logic [3:0]         rt_m_month, rt_o_month;
    logic [4:0]         rt_m_day, rt_o_day;
    logic signed [15:0] rt_m_year, rt_o_year;

    cdda_fj u_fj_main (
        .aclk  (aclk),
        .en    (en),
        .jd    (tj_jd_reg[0]),
        .month (rt_m_month),
        .day   (rt_m_day),
        .year  (rt_m_year)
    );

    cdda_fj u_fj_other (
        .aclk  (aclk),
        .en    (en),
        .jd    (tj_jd_reg[1]),
        .month (rt_o_month),
        .day   (rt_o_day),
        .year  (rt_o_year)
    );

    // ---------------- stage 13: select base dates, shift, difference ----------
    cdda_pkg::side_t    sd;
    cdda_pkg::jpair_t   jp;
    cdda_pkg::mid_t     mid_next;
    cdda_pkg::mid_t     mid_reg [cdda_pkg::FJ_LAT + 1];
    logic               main_ok, other_ok;
    logic [23:0]        bjd_main, bjd_other;
    logic signed [24:0] jd_shift;

    always_comb begin
        sd        = side_reg[11];
        jp        = jd_pipe[cdda_pkg::FJ_LAT-1];
        main_ok   = (rt_m_month == sd.month) && (rt_m_day == sd.day)
                    && (rt_m_year == $signed({2'b00, sd.year}));
        other_ok  = (rt_o_month == sd.other_month) && (rt_o_day == sd.other_day)
                    && (rt_o_year == $signed({2'b00, sd.other_year}));
        bjd_main  = main_ok ? jp.jd_main : default_jd;
        bjd_other = other_ok ? jp.jd_other : default_jd;
        jd_shift  = $signed({1'b0, bjd_main})
                    + $signed({{2{sd.offset[22]}}, sd.offset});
        mid_next.kind       = sd.kind;
        mid_next.main_ok    = main_ok;
        mid_next.other_ok   = other_ok;
        mid_next.base_month = main_ok ? sd.month : default_month_reg;
        mid_next.base_day   = main_ok ? sd.day : default_day_reg;
        mid_next.base_year  = main_ok ? sd.year : default_year_reg;
        mid_next.base_jd    = bjd_main;
        mid_next.diff       = 23'(bjd_main - bjd_other);
        mid_next.jd_shift   = jd_shift;
        mid_next.neg        = jd_shift[24];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg[0] <= mid_next;
            for (int i = 1; i <= cdda_pkg::FJ_LAT; i++) begin
                mid_reg[i] <= mid_reg[i-1];
            end
        end
    end

    // ---------------- stages 14..22: shifted Julian day back to a date ----------
    // a negative day number lies far before year 1: feed zero, flag it below
    logic [23:0]        fj_in;
    logic [3:0]         sh_month;
    logic [4:0]         sh_day;
    logic signed [15:0] sh_year;

    assign fj_in = mid_reg[0].neg ? 24'd0 : mid_reg[0].jd_shift[23:0];

    cdda_fj u_fj_shift (
        .aclk  (aclk),
        .en    (en),
        .jd    (fj_in),
        .month (sh_month),
        .day   (sh_day),
        .year  (sh_year)
    );

    // ---------------- stage 23: range check and output register ----------------
    cdda_pkg::mid_t mf;
    logic           oor;
    logic [3:0]     r_month;
    logic [4:0]     r_day;
    logic [13:0]    r_year;
    logic [23:0]    r_jd;

    always_comb begin
        mf = mid_reg[cdda_pkg::FJ_LAT];
        if (mf.kind == cdda_pkg::KIND_SHIFT) begin
            oor     = mf.neg || (sh_year < 16'sd1) || (sh_year > 16'sd9999);
            r_month = sh_month;
            r_day   = sh_day;
            r_year  = sh_year[13:0];
            r_jd    = mf.jd_shift[23:0];
        end else begin
            oor     = (mf.base_year == 14'd0) || (mf.base_year > 14'd9999);
            r_month = mf.base_month;
            r_day   = mf.base_day;
            r_year  = mf.base_year;
            r_jd    = mf.base_jd;
        end
        if (oor) begin
            r_month = default_month_reg;
            r_day   = default_day_reg;
            r_year  = default_year_reg;
            r_jd    = default_jd;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_result_month   <= r_month;
            m_result_day     <= r_day;
            m_result_year    <= r_year;
            m_julian_day     <= r_jd[22:0];
            m_day_difference <= (mf.kind == cdda_pkg::KIND_DIFF) ? $signed(mf.diff)
                                                                 : 23'sd0;
            m_main_valid     <= mf.main_ok;
            m_other_valid    <= mf.other_ok;
            m_out_of_range   <= oor;
        end
    end

    // ---------------- checks ----------------
    a_year_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |-> m_result_year >= 14'd1 && m_result_year <= 14'd9999)
        else $error("in-range result with year outside 1..9999");

    a_oor_default: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_result_month == default_month_reg
            && m_result_day == default_day_reg && m_result_year == default_year_reg)
        else $error("out-of-range result is not the default date");

    a_jd_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |-> m_julian_day >= 23'd1721000
            && m_julian_day <= 23'd5374000)
        else $error("julian day disagrees with an in-range year");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date arithmetic core testbench
// Drives date shift and date difference requests through the valid/ready
// channel, checks results against typed rows or an in-bench Julian day model
// and reprograms the default date over APB between traffic phases.
// ----------------------------------------------------------------------------
module testbench;

    // one result as the core reports it
    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] year;
        logic [22:0] jd;
        logic [22:0] diff;
        logic        main_ok;
        logic        other_ok;
        logic        oor;
    } date_res_t;

    // one directed row; typed rows carry their expected result
    typedef struct {
        logic               kind;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [13:0]        year;
        logic signed [22:0] offset;
        logic [3:0]         other_month;
        logic [4:0]         other_day;
        logic [13:0]        other_year;
        bit                 typed;
        date_res_t          res;
    } row_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_kind = 1'b0;
    logic [3:0]         s_month = '0;
    logic [4:0]         s_day = '0;
    logic [13:0]        s_year = '0;
    logic signed [22:0] s_offset = '0;
    logic [3:0]         s_other_month = '0;
    logic [4:0]         s_other_day = '0;
    logic [13:0]        s_other_year = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [3:0]         m_result_month;
    logic [4:0]         m_result_day;
    logic [13:0]        m_result_year;
    logic [22:0]        m_julian_day;
    logic signed [22:0] m_day_difference;
    logic               m_main_valid;
    logic               m_other_valid;
    logic               m_out_of_range;

    // bench copy of the default date registers
    logic [3:0]  dflt_month = 4'd5;
    logic [4:0]  dflt_day   = 5'd11;
    logic [13:0] dflt_year  = 14'd1959;

    date_res_t pending_dates[$];
    int        errors = 0;
    int        send_idle_pct = 0;   // sender gap chance, percent
    int        recv_stall_pct = 0;  // receiver stall chance, percent
    int        hold_cycles = 0;     // long receiver hold-off, counted below
    int        quiet_cycles = 0;

    calendar_date_day_arithmetic i_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Julian day model, C-style truncating division (longint '/')
    // ------------------------------------------------------------------
    function automatic longint julian_of(longint m, longint d, longint y);
        longint a;
        a = (m - 14) / 12;
        return d - 32075 + 1461 * (y + 4800 + a) / 4 + 367 * (m - 2 - a * 12) / 12
               - 3 * ((y + 4900 + a) / 100) / 4;
    endfunction

    function automatic void calendar_of(input longint jd,
                                        output longint m, output longint d,
                                        output longint y);
        longint l, n, i, j, k;
        l = jd + 68569;
        n = 4 * l / 146097;
        l = l - (146097 * n + 3) / 4;
        i = 4000 * (l + 1) / 1461001;
        l = l - 1461 * i / 4 + 31;
        j = 80 * l / 2447;
        k = l - 2447 * j / 80;
        l = j / 11;
        j = j + 2 - 12 * l;
        y = 100 * (n - 49) + i + l;
        m = j;
        d = k;
    endfunction

    // round-trip check; swaps in the default date when it fails
    function automatic bit settle_date(inout longint m, inout longint d, inout longint y);
        longint cm, cd, cy;
        calendar_of(julian_of(m, d, y), cm, cd, cy);
        if (cm == m && cd == d && cy == y)
            return 1'b1;
        m = dflt_month;
        d = dflt_day;
        y = dflt_year;
        return 1'b0;
    endfunction

    function automatic date_res_t date_arith(row_t r);
        date_res_t o;
        longint m, d, y, om, od, oy, jd, ojd, rm, rd, ry, diff;
        m = r.month; d = r.day; y = r.year;
        om = r.other_month; od = r.other_day; oy = r.other_year;
        diff = 0;
        o.main_ok  = settle_date(m, d, y);
        o.other_ok = settle_date(om, od, oy);
        jd  = julian_of(m, d, y);
        ojd = julian_of(om, od, oy);
        if (r.kind == cdda_pkg::KIND_SHIFT) begin
            jd += longint'(r.offset);
            calendar_of(jd, rm, rd, ry);
        end else begin
            rm = m; rd = d; ry = y;
            diff = jd - ojd;
        end
        o.oor = (ry < 1 || ry > 9999);
        if (o.oor) begin
            rm = dflt_month; rd = dflt_day; ry = dflt_year;
            jd = julian_of(rm, rd, ry);
        end
        o.month = rm[3:0];
        o.day   = rd[4:0];
        o.year  = ry[13:0];
        o.jd    = jd[22:0];
        o.diff  = diff[22:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic void pick_date(output logic [3:0] m, output logic [4:0] d,
                                      output logic [13:0] y);
        if ($urandom_range(99) < 15) begin
            // noise: any month and day the fields allow, years 0..9999
            m = 4'($urandom_range(15));
            d = 5'($urandom_range(31));
            y = 14'($urandom_range(9999));
        end else begin
            m = 4'($urandom_range(12, 1));
            d = 5'(($urandom_range(9) == 0) ? $urandom_range(31, 29) : $urandom_range(28, 1));
            case ($urandom_range(9))
                0:       y = 14'($urandom_range(3, 1));
                1:       y = 14'($urandom_range(9999, 9996));
                default: y = 14'($urandom_range(9999, 1));
            endcase
        end
    endfunction

    function automatic row_t random_request();
        row_t r;
        r.typed = 1'b0;
        r.res = '0;
        r.kind = $urandom_range(1) ? cdda_pkg::KIND_DIFF : cdda_pkg::KIND_SHIFT;
        pick_date(r.month, r.day, r.year);
        pick_date(r.other_month, r.other_day, r.other_year);
        case ($urandom_range(9))
            0:       r.offset = 23'($urandom);
            1, 2:    r.offset = 23'(int'($urandom_range(800000)) - 400000);
            default: r.offset = 23'(int'($urandom_range(2000)) - 1000);
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request driver: payload and valid change only on a rising edge
    // ------------------------------------------------------------------
    task automatic send_request(row_t r);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= r.kind;
        s_month       <= r.month;
        s_day         <= r.day;
        s_year        <= r.year;
        s_offset      <= r.offset;
        s_other_month <= r.other_month;
        s_other_day   <= r.other_day;
        s_other_year  <= r.other_year;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_dates.push_back(r.typed ? r.res : date_arith(r));
    endtask

    task automatic drain_requests();
        if (s_valid) s_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            cdda_pkg::REG_DEFAULT_MONTH: dflt_month = value[3:0];
            cdda_pkg::REG_DEFAULT_DAY:   dflt_day   = value[4:0];
            default:                     dflt_year  = value[13:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic set_default_date(int m, int d, int y);
        apb_write(cdda_pkg::REG_DEFAULT_MONTH, m);
        apb_write(cdda_pkg::REG_DEFAULT_DAY, d);
        apb_write(cdda_pkg::REG_DEFAULT_YEAR, y);
        @(posedge aclk);
    endtask

    task automatic random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_request(random_request());
    endtask

    // ------------------------------------------------------------------
    // directed table: reset default date is 1959-05-11 (JD 2436700)
    // 2000-01-01 is JD 2451545
    // ------------------------------------------------------------------
    row_t directed[] = '{
        // same date both sides: zero difference
        '{cdda_pkg::KIND_DIFF,  1, 1, 2000, 0, 1, 1, 2000, 1,
          '{4'd1, 5'd1, 14'd2000, 23'd2451545, 23'd0, 1'b1, 1'b1, 1'b0}},
        // invalid main date falls back to default
        '{cdda_pkg::KIND_DIFF,  0, 0, 0, 0, 1, 1, 2000, 1,
          '{4'd5, 5'd11, 14'd1959, 23'd2436700, 23'(-14845), 1'b0, 1'b1, 1'b0}},
        // step below year 1
        '{cdda_pkg::KIND_SHIFT, 1, 1, 1, -1, 1, 1, 2000, 1,
          '{4'd5, 5'd11, 14'd1959, 23'd2436700, 23'd0, 1'b1, 1'b1, 1'b1}},
        // step past year 9999
        '{cdda_pkg::KIND_SHIFT, 12, 31, 9999, 1, 1, 1, 2000, 1,
          '{4'd5, 5'd11, 14'd1959, 23'd2436700, 23'd0, 1'b1, 1'b1, 1'b1}},
        '{cdda_pkg::KIND_SHIFT, 1, 1, 1, 0, 12, 31, 9999, 0, '0},
        '{cdda_pkg::KIND_SHIFT, 2, 29, 2000, 365, 2, 29, 2004, 0, '0},
        '{cdda_pkg::KIND_SHIFT, 2, 29, 1900, 0, 2, 29, 1900, 0, '0},
        '{cdda_pkg::KIND_SHIFT, 15, 31, 9999, 4194303, 0, 0, 0, 0, '0},
        '{cdda_pkg::KIND_SHIFT, 1, 1, 2000, -4194304, 15, 31, 9999, 0, '0},
        '{cdda_pkg::KIND_SHIFT, 3, 1, 2000, -1, 13, 31, 0, 0, '0},
        '{cdda_pkg::KIND_SHIFT, 1, 1, 9999, 364, 4, 31, 2021, 0, '0},
        '{cdda_pkg::KIND_SHIFT, 6, 15, 5000, 1826212, 1, 1, 1, 0, '0},
        '{cdda_pkg::KIND_DIFF,  12, 31, 9999, 0, 1, 1, 1, 0, '0},
        '{cdda_pkg::KIND_DIFF,  1, 1, 1, 0, 12, 31, 9999, 0, '0},
        '{cdda_pkg::KIND_DIFF,  4, 31, 2021, -5, 2, 30, 2000, 0, '0},
        '{cdda_pkg::KIND_DIFF,  2, 29, 2004, 4194303, 14, 16, 8191, 0, '0}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_request(directed[i]);
        drain_requests();

        // latest possible default date
        set_default_date(12, 31, 9999);
        foreach (directed[i])
            if (!directed[i].typed) send_request(directed[i]);
        random_phase(250, 0, 0);
        drain_requests();

        // earliest possible default date
        set_default_date(1, 1, 1);
        random_phase(250, 48, 0);
        // sender waits for every result before going on
        drain_requests();
        random_phase(20, 0, 0);
        drain_requests();

        // a default that is no real date is used as written
        set_default_date(2, 30, 2000);
        random_phase(250, 0, 48);
        drain_requests();

        set_default_date($urandom_range(12, 1), $urandom_range(31, 1),
                         $urandom_range(9999, 1));
        random_phase(250, 29, 29);

        // long receiver hold-off while the sender keeps pushing: pipe fills
        hold_cycles = 300;
        random_phase(100, 0, 0);
        drain_requests();

        if (errors == 0 && pending_dates.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side ready: random stalls plus the long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker, in arrival order
    always @(posedge aclk) begin
        date_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: result with no request outstanding", $realtime);
                errors++;
            end else begin
                e = pending_dates.pop_front();
                check_field("result_month", e.month, m_result_month);
                check_field("result_day", e.day, m_result_day);
                check_field("result_year", e.year, m_result_year);
                check_field("julian_day", e.jd, m_julian_day);
                check_field("day_difference", $signed(e.diff), m_day_difference);
                check_field("main_valid", e.main_ok, m_main_valid);
                check_field("other_valid", e.other_ok, m_other_valid);
                check_field("out_of_range", e.oor, m_out_of_range);
            end
        end
    end

    // watchdog: no handshake on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
